// ===== hw/rtl/fms_pkg.sv =====
// Package for the focuser motion supervisor.
// Holds the item, result, register and state types and the command codes.
// No dependencies.
package fms_pkg;

	localparam int POS_W = 32;          // position / limit width in steps
	localparam int SUM_W = POS_W + 2;   // full-width sums for limit checks

	// input command codes
	localparam logic [3:0] CMD_JOG_FWD  = 4'd0;
	localparam logic [3:0] CMD_JOG_BACK = 4'd1;
	localparam logic [3:0] CMD_STOP_JOG = 4'd2;
	localparam logic [3:0] CMD_HALT     = 4'd3;
	localparam logic [3:0] CMD_MOVE_ABS = 4'd4;
	localparam logic [3:0] CMD_MOVE_REL = 4'd5;
	localparam logic [3:0] CMD_HOME     = 4'd6;
	localparam logic [3:0] CMD_SET_POS  = 4'd7;
	localparam logic [3:0] CMD_SET_EN   = 4'd8;
	localparam logic [3:0] CMD_TOGGLE   = 4'd9;
	localparam logic [3:0] CMD_ENDSTOP  = 4'd10;
	localparam logic [3:0] CMD_TICK     = 4'd11;

	// motion commands toward the generator
	localparam logic [2:0] MC_NONE      = 3'd0;
	localparam logic [2:0] MC_RUN_FWD   = 3'd1;
	localparam logic [2:0] MC_RUN_BACK  = 3'd2;
	localparam logic [2:0] MC_DECEL     = 3'd3;
	localparam logic [2:0] MC_FORCE_STOP = 3'd4;
	localparam logic [2:0] MC_MOVE_TO   = 3'd5;
	localparam logic [2:0] MC_SET_POS   = 3'd6;
	localparam logic [2:0] MC_ZERO_MOVE = 3'd7;

	// move status
	localparam logic [1:0] MS_IDLE   = 2'd0;
	localparam logic [1:0] MS_MOVING = 2'd1;
	localparam logic [1:0] MS_HOMING = 2'd2;

	// register indexes
	localparam logic [2:0] REG_SOFT_MIN   = 3'd0;
	localparam logic [2:0] REG_SOFT_MAX   = 3'd1;
	localparam logic [2:0] REG_IDLE_TMO   = 3'd2;
	localparam logic [2:0] REG_HOME_RET   = 3'd3;
	localparam logic [2:0] REG_HOME_SEEK  = 3'd4;
	localparam logic [2:0] REG_JOG_LOOK   = 3'd5;
	localparam logic [2:0] REG_SPEED_SEL  = 3'd6;

	typedef struct packed {
		logic        [3:0]       cmd;
		logic signed [POS_W-1:0] value;
		logic signed [POS_W-1:0] current_position;
		logic                    motor_running;
		logic                    endstop_level;
	} item_t;

	typedef struct packed {
		logic        [2:0]       motion_cmd;
		logic signed [POS_W-1:0] motion_target;
		logic                    speed_mode;
		logic                    outputs_enabled;
		logic        [1:0]       move_status;
		logic                    rejected;
		logic                    save_position;
		logic                    homing_done;
	} result_t;

	typedef struct packed {
		logic signed [POS_W-1:0] soft_min_steps;
		logic signed [POS_W-1:0] soft_max_steps;
		logic        [31:0]      idle_timeout_ms;
		logic signed [POS_W-1:0] homing_return_steps;
		logic signed [POS_W-1:0] homing_seek_target;
		logic        [15:0]      jog_lookahead_steps;
		logic        [2:0]       speed_select;
	} cfg_t;

	typedef struct packed {
		logic        motor_on;
		logic        jog_running;
		logic        homing_seek;
		logic        homing_return;
		logic        endstop_hit;
		logic        was_moving;
		logic [31:0] idle_count;
	} state_t;

endpackage

// ===== hw/rtl/fms_cfg.sv =====
// Configuration register file of the focuser motion supervisor.
// Depends on fms_pkg (cfg_t, register indexes).
module fms_cfg import fms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.soft_min_steps      <= '0;
			cfg_q.soft_max_steps      <= POS_W'(100000);
			cfg_q.idle_timeout_ms     <= 32'd60000;
			cfg_q.homing_return_steps <= '0;
			cfg_q.homing_seek_target  <= -POS_W'(100000);
			cfg_q.jog_lookahead_steps <= 16'd250;
			cfg_q.speed_select        <= 3'd1;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SOFT_MIN:  cfg_q.soft_min_steps      <= wr_data[POS_W-1:0];
				REG_SOFT_MAX:  cfg_q.soft_max_steps      <= wr_data[POS_W-1:0];
				REG_IDLE_TMO:  cfg_q.idle_timeout_ms     <= wr_data;
				REG_HOME_RET:  cfg_q.homing_return_steps <= wr_data[POS_W-1:0];
				REG_HOME_SEEK: cfg_q.homing_seek_target  <= wr_data[POS_W-1:0];
				REG_JOG_LOOK:  cfg_q.jog_lookahead_steps <= wr_data[15:0];
				REG_SPEED_SEL: cfg_q.speed_select        <= wr_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/fms_step.sv =====
// Per-item decision logic of the focuser motion supervisor: from the held item,
// the supervisor state and the registers, the next state and the result.
// Depends on fms_pkg.
module fms_step import fms_pkg::*; (
	input  item_t   item,
	input  state_t  st,
	input  cfg_t    cfg,
	output state_t  nx,
	output result_t res
);

	logic signed [SUM_W-1:0] fwd_t, move_t, lim_lo, lim_hi;
	logic                    fwd_ok, move_ok, homing, homing_nx, en_val;
	logic [2:0]              mc;
	logic signed [POS_W-1:0] target;
	logic                    rej, save, done;

	// full-width sums: an overflowing target simply falls outside the limits
	assign lim_lo = SUM_W'(cfg.soft_min_steps);
	assign lim_hi = SUM_W'(cfg.soft_max_steps);
	assign fwd_t  = SUM_W'(item.current_position)
	              + $signed({{(SUM_W-16){1'b0}}, cfg.jog_lookahead_steps});
	assign move_t = (item.cmd == CMD_MOVE_ABS) ? SUM_W'(item.value)
	              : SUM_W'(item.current_position) + SUM_W'(item.value);
	assign fwd_ok  = (fwd_t >= lim_lo) && (fwd_t <= lim_hi);
	assign move_ok = (move_t >= lim_lo) && (move_t <= lim_hi);
	assign homing  = st.homing_seek | st.homing_return;
	assign en_val  = (item.cmd == CMD_SET_EN) ? (item.value != '0) : !st.motor_on;

	always_comb begin
		nx     = st;
		mc     = MC_NONE;
		target = '0;
		rej    = 1'b0;
		save   = 1'b0;
		done   = 1'b0;
		case (item.cmd) inside
			CMD_JOG_FWD, CMD_JOG_BACK: begin
				if (!homing) begin
					if (!st.motor_on) begin
						nx.motor_on   = 1'b1;
						nx.idle_count = '0;
					end
					if (item.cmd == CMD_JOG_FWD && !fwd_ok) begin
						rej = 1'b1;
					end else if (item.cmd == CMD_JOG_BACK && item.endstop_level) begin
						rej = 1'b1;
					end else begin
						nx.idle_count  = '0;
						nx.jog_running = 1'b1;
						mc = (item.cmd == CMD_JOG_FWD) ? MC_RUN_FWD : MC_RUN_BACK;
					end
				end
			end
			CMD_STOP_JOG: begin
				if (!homing && st.jog_running) begin
					mc             = MC_DECEL;
					nx.jog_running = 1'b0;
					nx.idle_count  = '0;
				end
			end
			CMD_HALT: begin
				mc               = MC_FORCE_STOP;
				nx.jog_running   = 1'b0;
				nx.homing_seek   = 1'b0;
				nx.homing_return = 1'b0;
				nx.motor_on      = 1'b0;
				nx.endstop_hit   = 1'b0;
				nx.idle_count    = '0;
			end
			CMD_MOVE_ABS, CMD_MOVE_REL: begin
				if (!st.motor_on) begin
					nx.motor_on   = 1'b1;
					nx.idle_count = '0;
				end
				if (!move_ok) begin
					rej = 1'b1;
				end else begin
					nx.jog_running = 1'b0;
					nx.idle_count  = '0;
					mc             = MC_MOVE_TO;
					target         = move_t[POS_W-1:0];
				end
			end
			CMD_HOME: begin
				nx.homing_return = 1'b0;
				nx.homing_seek   = 1'b1;
				nx.jog_running   = 1'b0;
				nx.endstop_hit   = 1'b0;
				nx.motor_on      = 1'b1;
				nx.idle_count    = '0;
				mc               = MC_MOVE_TO;
				target           = cfg.homing_seek_target;
			end
			CMD_SET_POS: begin
				mc     = MC_SET_POS;
				target = item.value;
			end
			CMD_SET_EN, CMD_TOGGLE: begin
				nx.motor_on   = en_val;
				nx.idle_count = '0;
				if (!en_val) begin
					nx.jog_running = 1'b0;
					mc             = MC_DECEL;
				end
			end
			CMD_ENDSTOP: begin
				if (homing) begin
					nx.endstop_hit = 1'b1;
				end else begin
					mc             = MC_SET_POS;
					nx.jog_running = 1'b0;
					nx.idle_count  = '0;
				end
			end
			CMD_TICK: begin
				if (st.idle_count != '1)
					nx.idle_count = st.idle_count + 32'd1;
				// homing sequencer
				if (st.homing_seek) begin
					if (!st.motor_on) begin
						mc               = MC_FORCE_STOP;
						nx.jog_running   = 1'b0;
						nx.homing_seek   = 1'b0;
						nx.homing_return = 1'b0;
						nx.endstop_hit   = 1'b0;
						nx.idle_count    = '0;
					end else begin
						nx.idle_count = '0;
						if (st.homing_return) begin
							if (!item.motor_running) begin
								nx.homing_seek   = 1'b0;
								nx.homing_return = 1'b0;
								save             = 1'b1;
								done             = 1'b1;
							end
						end else if (st.endstop_hit || item.endstop_level) begin
							nx.endstop_hit   = 1'b0;
							mc               = MC_ZERO_MOVE;
							target           = cfg.homing_return_steps;
							nx.homing_return = 1'b1;
						end
					end
				end
				// clamp above the upper limit
				if (mc == MC_NONE && !nx.homing_seek && nx.motor_on
				    && item.current_position > cfg.soft_max_steps) begin
					mc             = MC_SET_POS;
					target         = cfg.soft_max_steps;
					nx.jog_running = 1'b0;
					nx.idle_count  = '0;
				end
				// idle disable
				if (nx.motor_on && !nx.homing_seek && !nx.homing_return) begin
					if (nx.jog_running || item.motor_running) begin
						nx.idle_count = '0;
					end else if (nx.idle_count >= cfg.idle_timeout_ms) begin
						nx.motor_on    = 1'b0;
						nx.idle_count  = '0;
						nx.jog_running = 1'b0;
						if (mc == MC_NONE)
							mc = MC_DECEL;
					end
				end
				// save when a move ends
				if (nx.homing_seek || nx.homing_return) begin
					nx.was_moving = 1'b1;
				end else begin
					if (st.was_moving && !item.motor_running)
						save = 1'b1;
					nx.was_moving = item.motor_running;
				end
			end
			default: ;
		endcase
	end

	assign homing_nx = nx.homing_seek | nx.homing_return;

	always_comb begin
		res.motion_cmd      = mc;
		res.motion_target   = target;
		res.speed_mode      = homing_nx;
		res.outputs_enabled = nx.motor_on;
		if (homing_nx)
			res.move_status = MS_HOMING;
		else if (nx.jog_running || item.motor_running || mc == MC_RUN_FWD
		         || mc == MC_RUN_BACK || mc == MC_MOVE_TO || mc == MC_ZERO_MOVE)
			res.move_status = MS_MOVING;
		else
			res.move_status = MS_IDLE;
		res.rejected      = rej;
		res.save_position = save;
		res.homing_done   = done;
	end

endmodule

// ===== hw/rtl/focuser_motion_supervisor.sv =====
// Top level of the focuser motion supervisor: input register, state, result register.
// Depends on fms_pkg, fms_cfg and fms_step.
//
//  channel   direction  handshake               payload
//  item      in         item_valid / item_stall   item_t (cmd, value, position, flags)
//  result    out        result_valid / result_stall  result_t (one per item)
//  cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle while result_stall stays low; an item passes the item register, then the result register.
// The item register feeds one pass of decision logic that updates the state and
// loads the result register in the same edge. A stalled result holds; the item
// register still accepts one more transfer, then item_stall rises.
// Reset clears state, registers to their defaults and both valid flags.
// cfg_ready is always high; each write is registered in fms_cfg.
module focuser_motion_supervisor import fms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	state_t  st_q;

	cfg_t    cfg;
	state_t  st_nx;
	result_t res_nx;

	logic    accept;    // input transfer this edge
	logic    advance;   // held item resolves into the result register

	assign cfg_ready = 1'b1;

	fms_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	fms_step u_step (
		.item (item_s1),
		.st   (st_q),
		.cfg  (cfg),
		.nx   (st_nx),
		.res  (res_nx)
	);

	// the result slot frees when it is empty or being taken this edge
	assign advance    = valid_s1 & (~valid_s2 | ~result_stall);
	assign item_stall = valid_s1 & valid_s2 & result_stall;
	assign accept     = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else begin
			valid_s1 <= accept | (valid_s1 & ~advance);
			if (advance) begin
				valid_s2 <= 1'b1;
				st_q     <= st_nx;
			end else if (~result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= item;
		if (advance)
			result_s2 <= res_nx;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// ===== tb/sv/fms_motion_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the focuser motion supervisor: watches the item, result and
// config channels, predicts every result and compares it field by field.
// Depends on fms_pkg.
module fms_motion_checker import fms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_stall,
	input  item_t       item,
	input  logic        result_valid,
	input  logic        result_stall,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          pending
);

	localparam logic [15:0]             LOOKAHEAD_DEFAULT = 16'd250;
	localparam logic signed [POS_W-1:0] SEEK_DEFAULT      = -32'sd100000;

	cfg_t        limits;
	logic        drv_on, jogging, seeking, returning, stop_latched, moving_before;
	logic [31:0] idle_ticks;
	result_t     owed[$];
	result_t     want, fresh;

	function automatic logic in_window(longint t);
		return t >= longint'($signed(limits.soft_min_steps)) &&
			t <= longint'($signed(limits.soft_max_steps));
	endfunction

	task automatic set_drive(input logic en, inout logic [2:0] mc);
		drv_on = en;
		idle_ticks = '0;
		if (!en) begin
			jogging = 1'b0;
			if (mc == MC_NONE)
				mc = MC_DECEL;
		end
	endtask

	task automatic check_field(input string name, input longint exp, input longint act);
		if (exp != act) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
		end
	endtask

	// one item through the supervisor, updating the shadow state
	task automatic supervise(input item_t it, output result_t r);
		logic [2:0]         mc;
		logic signed [31:0] tgt;
		logic               rej, save, done, homing;
		longint             cur, t;
		mc = MC_NONE;
		tgt = '0;
		rej = 1'b0;
		save = 1'b0;
		done = 1'b0;
		homing = seeking || returning;
		cur = longint'($signed(it.current_position));
		case (it.cmd)
		CMD_JOG_FWD, CMD_JOG_BACK: begin
			if (!homing) begin
				if (!drv_on)
					set_drive(1'b1, mc);
				t = cur + longint'(limits.jog_lookahead_steps);
				if ((it.cmd == CMD_JOG_FWD) ? !in_window(t) : it.endstop_level) begin
					rej = 1'b1;
				end else begin
					idle_ticks = '0;
					jogging = 1'b1;
					mc = (it.cmd == CMD_JOG_FWD) ? MC_RUN_FWD : MC_RUN_BACK;
				end
			end
		end
		CMD_STOP_JOG: begin
			if (!homing && jogging) begin
				mc = MC_DECEL;
				jogging = 1'b0;
				idle_ticks = '0;
			end
		end
		CMD_HALT: begin
			mc = MC_FORCE_STOP;
			jogging = 1'b0;
			seeking = 1'b0;
			returning = 1'b0;
			drv_on = 1'b0;
			stop_latched = 1'b0;
			idle_ticks = '0;
		end
		CMD_MOVE_ABS, CMD_MOVE_REL: begin
			if (!drv_on)
				set_drive(1'b1, mc);
			t = longint'($signed(it.value));
			if (it.cmd == CMD_MOVE_REL)
				t += cur;
			if (!in_window(t)) begin
				rej = 1'b1;
			end else begin
				jogging = 1'b0;
				idle_ticks = '0;
				mc = MC_MOVE_TO;
				tgt = t[31:0];
			end
		end
		CMD_HOME: begin
			returning = 1'b0;
			seeking = 1'b1;
			jogging = 1'b0;
			stop_latched = 1'b0;
			set_drive(1'b1, mc);
			mc = MC_MOVE_TO;
			tgt = limits.homing_seek_target;
		end
		CMD_SET_POS: begin
			mc = MC_SET_POS;
			tgt = it.value;
		end
		CMD_SET_EN:  set_drive(it.value != '0, mc);
		CMD_TOGGLE:  set_drive(!drv_on, mc);
		CMD_ENDSTOP: begin
			if (homing) begin
				stop_latched = 1'b1;
			end else begin
				mc = MC_SET_POS;
				tgt = '0;
				jogging = 1'b0;
				idle_ticks = '0;
			end
		end
		CMD_TICK: begin
			if (idle_ticks != '1)
				idle_ticks++;
			if (seeking) begin
				if (!drv_on) begin
					// driver went off mid-homing: abort
					mc = MC_FORCE_STOP;
					jogging = 1'b0;
					seeking = 1'b0;
					returning = 1'b0;
					stop_latched = 1'b0;
					idle_ticks = '0;
				end else begin
					idle_ticks = '0;
					if (returning) begin
						if (!it.motor_running) begin
							seeking = 1'b0;
							returning = 1'b0;
							save = 1'b1;
							done = 1'b1;
						end
					end else if (stop_latched || it.endstop_level) begin
						stop_latched = 1'b0;
						mc = MC_ZERO_MOVE;
						tgt = limits.homing_return_steps;
						returning = 1'b1;
					end
				end
			end
			if (mc == MC_NONE && !seeking && drv_on &&
				cur > longint'($signed(limits.soft_max_steps))) begin
				mc = MC_SET_POS;
				tgt = limits.soft_max_steps;
				jogging = 1'b0;
				idle_ticks = '0;
			end
			if (drv_on && !seeking && !returning) begin
				if (jogging || it.motor_running)
					idle_ticks = '0;
				else if (idle_ticks >= limits.idle_timeout_ms)
					set_drive(1'b0, mc);
			end
			if (seeking || returning) begin
				moving_before = 1'b1;
			end else begin
				if (moving_before && !it.motor_running)
					save = 1'b1;
				moving_before = it.motor_running;
			end
		end
		default: ;
		endcase

		homing = seeking || returning;
		r.motion_cmd = mc;
		r.motion_target = (mc >= MC_MOVE_TO) ? tgt : '0;
		r.speed_mode = homing;
		r.outputs_enabled = drv_on;
		if (homing)
			r.move_status = MS_HOMING;
		else if (jogging || it.motor_running || mc == MC_RUN_FWD || mc == MC_RUN_BACK ||
			mc == MC_MOVE_TO || mc == MC_ZERO_MOVE)
			r.move_status = MS_MOVING;
		else
			r.move_status = MS_IDLE;
		r.rejected = rej;
		r.save_position = save;
		r.homing_done = done;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits.soft_min_steps <= '0;
			limits.soft_max_steps <= 32'sd100000;
			limits.idle_timeout_ms <= 32'd60000;
			limits.homing_return_steps <= '0;
			limits.homing_seek_target <= SEEK_DEFAULT;
			limits.jog_lookahead_steps <= LOOKAHEAD_DEFAULT;
			limits.speed_select <= 3'd1;
			drv_on <= 1'b0;
			jogging <= 1'b0;
			seeking <= 1'b0;
			returning <= 1'b0;
			stop_latched <= 1'b0;
			moving_before <= 1'b0;
			idle_ticks <= '0;
			owed.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (owed.size() == 0) begin
					mismatches++;
					$display("%0t: result with none expected, expected nothing, got %h",
						$time, result);
				end else begin
					want = owed.pop_front();
					check_field("motion_cmd", want.motion_cmd, result.motion_cmd);
					check_field("motion_target", longint'($signed(want.motion_target)),
						longint'($signed(result.motion_target)));
					check_field("speed_mode", want.speed_mode, result.speed_mode);
					check_field("outputs_enabled", want.outputs_enabled,
						result.outputs_enabled);
					check_field("move_status", want.move_status, result.move_status);
					check_field("rejected", want.rejected, result.rejected);
					check_field("save_position", want.save_position, result.save_position);
					check_field("homing_done", want.homing_done, result.homing_done);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_SOFT_MIN:  limits.soft_min_steps = cfg_data;
				REG_SOFT_MAX:  limits.soft_max_steps = cfg_data;
				REG_IDLE_TMO:  limits.idle_timeout_ms = cfg_data;
				REG_HOME_RET:  limits.homing_return_steps = cfg_data;
				REG_HOME_SEEK: limits.homing_seek_target = cfg_data;
				REG_JOG_LOOK:  limits.jog_lookahead_steps = cfg_data[15:0];
				REG_SPEED_SEL: limits.speed_select = cfg_data[2:0];
				default: ;
				endcase
			end
			if (item_valid && !item_stall) begin
				supervise(item, fresh);
				owed.push_back(fresh);
			end
			pending = owed.size();
		end
	end

endmodule

// ===== tb/sv/tb_focuser_motion_supervisor.sv =====
`timescale 1ns / 100ps
// Testbench top for the focuser motion supervisor: clock, reset, stimulus and verdict.
// Depends on fms_pkg, focuser_motion_supervisor and fms_motion_checker.
module tb_focuser_motion_supervisor;
	import fms_pkg::*;

	// cmd code with no meaning; the block must ignore it
	localparam logic [3:0] CMD_UNUSED    = 4'd15;
	// register index past the last one; writes must be dropped
	localparam logic [2:0] REG_UNUSED    = 3'd7;
	localparam int         CYCLE_LIMIT   = 200000;
	localparam int         SETTLE_CYCLES = 4;   // a little over the latency through the item and result registers
	localparam int         RAND_PHASES   = 5;
	localparam int         PHASE_ITEMS   = 360;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int          mismatches, pending;
	int          items_sent;
	int          send_gap_pct, stall_pct;   // idling odds, percent per cycle
	int          cycles;
	cfg_t        regs;                      // what we last programmed

	focuser_motion_supervisor u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	fms_motion_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result side back-pressure: a fresh coin each cycle.
	always @(posedge clk)
		result_stall <= ($urandom_range(99) < stall_pct);

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	function automatic item_t make_cmd(logic [3:0] c, logic [31:0] v, logic [31:0] p,
		logic run, logic lvl);
		item_t it;
		it.cmd = c;
		it.value = v;
		it.current_position = p;
		it.motor_running = run;
		it.endstop_level = lvl;
		return it;
	endfunction

	// Position biased toward the programmed soft window and its edges,
	// with the odd fully random one so every bit toggles.
	function automatic logic [31:0] pick_pos();
		longint lo, hi, p;
		lo = longint'($signed(regs.soft_min_steps));
		hi = longint'($signed(regs.soft_max_steps));
		case ($urandom_range(9))
		0: p = longint'($urandom);
		1: p = hi + longint'($urandom_range(600)) - 300;
		2: p = lo + longint'($urandom_range(600)) - 300;
		default: begin
			if (hi >= lo)
				p = lo + longint'($urandom) % (hi - lo + 1);
			else
				p = longint'($urandom);
		end
		endcase
		return p[31:0];
	endfunction

	// Loose single item; most unused codes are folded into ticks.
	function automatic item_t random_item();
		item_t  it;
		longint off;
		it.cmd = 4'($urandom_range(15));
		if (it.cmd > CMD_TICK && $urandom_range(3) != 0)
			it.cmd = CMD_TICK;
		off = longint'($urandom_range(4000)) - 2000;
		it.value = $urandom_range(1) ? $urandom : off[31:0];
		if (it.cmd == CMD_MOVE_ABS && $urandom_range(1))
			it.value = pick_pos();
		it.current_position = pick_pos();
		it.motor_running = 1'($urandom_range(1));
		it.endstop_level = ($urandom_range(4) == 0);
		return it;
	endfunction

	// One transfer on the item channel. Optional idle gap first, then hold
	// valid and payload until the edge with stall low.
	task automatic push_item(input item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	// Stop sending and let every outstanding result come back.
	// pending is read at the falling edge, away from the checker's update.
	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes are back to back; valid drops once at the end.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs();
		logic [31:0] junk;
		junk = $urandom;
		write_reg(REG_SOFT_MIN, regs.soft_min_steps);
		write_reg(REG_SOFT_MAX, regs.soft_max_steps);
		write_reg(REG_IDLE_TMO, regs.idle_timeout_ms);
		write_reg(REG_HOME_RET, regs.homing_return_steps);
		write_reg(REG_HOME_SEEK, regs.homing_seek_target);
		// junk in the upper bits must not leak into the narrow registers
		write_reg(REG_JOG_LOOK, {junk[15:0], regs.jog_lookahead_steps});
		write_reg(REG_SPEED_SEL, {junk[31:3], regs.speed_select});
		write_reg(REG_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// Full homing: start, seek ticks, endstop (edge or level), return ticks,
	// then the generator stops. Sometimes a stray command lands mid-sequence.
	task automatic home_run();
		push_item(make_cmd(CMD_HOME, $urandom, pick_pos(), 1'($urandom_range(1)), 1'b0));
		repeat ($urandom_range(3))
			push_item(make_cmd(CMD_TICK, $urandom, pick_pos(), 1'b1, 1'b0));
		if ($urandom_range(3) == 0)
			push_item(random_item());
		if ($urandom_range(1)) begin
			push_item(make_cmd(CMD_ENDSTOP, $urandom, pick_pos(), 1'b1, 1'b1));
			push_item(make_cmd(CMD_TICK, $urandom, pick_pos(), 1'b1,
				1'($urandom_range(1))));
		end else begin
			push_item(make_cmd(CMD_TICK, $urandom, pick_pos(), 1'b1, 1'b1));
		end
		repeat ($urandom_range(3))
			push_item(make_cmd(CMD_TICK, $urandom, pick_pos(), 1'b1, 1'b0));
		push_item(make_cmd(CMD_TICK, $urandom, pick_pos(), 1'b0, 1'b0));
	endtask

	// Move, run for a while, stop, then idle ticks toward the timeout.
	task automatic move_run();
		item_t it;
		it = random_item();
		it.cmd = $urandom_range(1) ? CMD_MOVE_ABS : CMD_MOVE_REL;
		if (it.cmd == CMD_MOVE_ABS)
			it.value = pick_pos();
		push_item(it);
		repeat ($urandom_range(4))
			push_item(make_cmd(CMD_TICK, $urandom, pick_pos(), 1'b1, 1'b0));
		repeat ($urandom_range(1, 8))
			push_item(make_cmd(CMD_TICK, $urandom, pick_pos(), 1'b0, 1'b0));
	endtask

	// Jog, a few ticks, ended by stop, halt or an endstop edge.
	task automatic jog_run();
		push_item(make_cmd($urandom_range(1) ? CMD_JOG_BACK : CMD_JOG_FWD, $urandom,
			pick_pos(), 1'($urandom_range(1)), $urandom_range(4) == 0));
		repeat ($urandom_range(3))
			push_item(make_cmd(CMD_TICK, $urandom, pick_pos(), 1'b1, 1'b0));
		case ($urandom_range(3))
		0: push_item(make_cmd(CMD_HALT, $urandom, pick_pos(), 1'b1, 1'b0));
		1: push_item(make_cmd(CMD_ENDSTOP, $urandom, pick_pos(), 1'b1, 1'b1));
		default: push_item(make_cmd(CMD_STOP_JOG, $urandom, pick_pos(), 1'b1, 1'b0));
		endcase
		repeat ($urandom_range(4))
			push_item(make_cmd(CMD_TICK, $urandom, pick_pos(), 1'b0, 1'b0));
	endtask

	// Mostly well-formed sequences, the rest loose items. Now and then the
	// sender holds off until the block has nothing in flight.
	task automatic run_random(input int n);
		int stop_at;
		int pick;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick == 0)
				wait_drained();
			if (pick < 20)
				home_run();
			else if (pick < 40)
				move_run();
			else if (pick < 55)
				jog_run();
			else
				push_item(random_item());
		end
	endtask

	initial begin
		int     ph;
		longint lo, hi;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		items_sent = 0;
		send_gap_pct = 0;
		stall_pct = 0;
		regs = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset config (window 0..100000, look-ahead 250).
		push_item(make_cmd(CMD_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1));
		// backward jog with driver off and endstop pressed: enables, then refuses
		push_item(make_cmd(CMD_JOG_BACK, 0, 500, 1'b0, 1'b1));
		// forward look-ahead just past the top, then landing exactly on it
		push_item(make_cmd(CMD_JOG_FWD, 0, 99800, 1'b0, 1'b0));
		push_item(make_cmd(CMD_JOG_FWD, 0, 99750, 1'b0, 1'b0));
		push_item(make_cmd(CMD_STOP_JOG, 0, 99900, 1'b1, 1'b0));
		push_item(make_cmd(CMD_JOG_BACK, 0, 1000, 1'b0, 1'b0));
		push_item(make_cmd(CMD_HALT, 0, 900, 1'b1, 1'b0));
		// moves with driver off; relative sums that overflow 32 bits
		push_item(make_cmd(CMD_MOVE_ABS, 32'h7FFFFFFF, 0, 1'b0, 1'b0));
		push_item(make_cmd(CMD_MOVE_REL, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b0, 1'b0));
		push_item(make_cmd(CMD_MOVE_REL, 32'h80000000, 32'h80000000, 1'b0, 1'b0));
		push_item(make_cmd(CMD_MOVE_REL, -32'sd100, 600, 1'b0, 1'b0));
		push_item(make_cmd(CMD_MOVE_ABS, 0, 500, 1'b1, 1'b0));
		push_item(make_cmd(CMD_SET_POS, 32'h80000000, 32'h7FFFFFFF, 1'b0, 1'b0));
		push_item(make_cmd(CMD_SET_EN, 0, 0, 1'b0, 1'b0));
		push_item(make_cmd(CMD_SET_EN, 32'hFFFFFFFF, 0, 1'b0, 1'b0));
		push_item(make_cmd(CMD_ENDSTOP, 0, 300, 1'b0, 1'b1));
		// over the top with driver on: clamp
		push_item(make_cmd(CMD_TICK, 0, 100001, 1'b0, 1'b0));
		// homing; jog ignored, move still issued, endstop latched, return, done
		push_item(make_cmd(CMD_HOME, 0, 5000, 1'b0, 1'b0));
		push_item(make_cmd(CMD_JOG_FWD, 0, 5000, 1'b1, 1'b0));
		push_item(make_cmd(CMD_MOVE_ABS, 1000, 5000, 1'b1, 1'b0));
		push_item(make_cmd(CMD_ENDSTOP, 0, 10, 1'b1, 1'b1));
		push_item(make_cmd(CMD_TICK, 0, 0, 1'b1, 1'b0));
		push_item(make_cmd(CMD_TICK, 0, 0, 1'b0, 1'b0));
		// motion ends outside homing: save pulse
		push_item(make_cmd(CMD_TICK, 0, 0, 1'b1, 1'b0));
		push_item(make_cmd(CMD_TICK, 0, 0, 1'b0, 1'b0));
		// homing aborted because the driver was switched off
		push_item(make_cmd(CMD_HOME, 0, 0, 1'b0, 1'b0));
		push_item(make_cmd(CMD_TOGGLE, 0, 0, 1'b0, 1'b0));
		push_item(make_cmd(CMD_TICK, 0, 0, 1'b1, 1'b0));
		wait_drained();

		// Random phases, each with its own register set and idling mix.
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			case (ph)
			0: begin
				regs.soft_min_steps = -32'sd5000;
				regs.soft_max_steps = 32'sd20000;
				regs.idle_timeout_ms = 32'd5;
				regs.homing_return_steps = 32'sd100;
				regs.homing_seek_target = -32'sd30000;
				regs.jog_lookahead_steps = 16'd250;
				regs.speed_select = 3'd0;
			end
			1: begin
				// widest window; zero timeout disables on the first idle tick
				regs.soft_min_steps = 32'h80000000;
				regs.soft_max_steps = 32'h7FFFFFFF;
				regs.idle_timeout_ms = '0;
				regs.homing_return_steps = 32'h7FFFFFFF;
				regs.homing_seek_target = 32'h80000000;
				regs.jog_lookahead_steps = 16'hFFFF;
				regs.speed_select = 3'd4;
			end
			2: begin
				// inverted window: every limit check fails
				regs.soft_min_steps = 32'sd1000;
				regs.soft_max_steps = -32'sd1000;
				regs.idle_timeout_ms = 32'hFFFFFFFF;
				regs.homing_return_steps = -32'sd1;
				regs.homing_seek_target = '0;
				regs.jog_lookahead_steps = '0;
				regs.speed_select = 3'd2;
			end
			default: begin
				lo = -longint'($urandom_range(50000));
				hi = longint'($urandom_range(60000));
				regs.soft_min_steps = lo[31:0];
				regs.soft_max_steps = hi[31:0];
				regs.idle_timeout_ms = $urandom_range(20);
				regs.homing_return_steps = pick_pos();
				lo = lo - longint'($urandom_range(5000));
				regs.homing_seek_target = lo[31:0];
				regs.jog_lookahead_steps = 16'($urandom_range(600));
				regs.speed_select = 3'($urandom_range(4));
			end
			endcase
			program_regs();
			case (ph % 4)
			0: begin send_gap_pct = 0;  stall_pct = 0;  end
			1: begin send_gap_pct = 51; stall_pct = 0;  end
			2: begin send_gap_pct = 0;  stall_pct = 51; end
			default: begin send_gap_pct = 18; stall_pct = 18; end
			endcase
			run_random(PHASE_ITEMS);
			wait_drained();
		end

		@(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/fms_pkg.sv
hw/rtl/fms_cfg.sv
hw/rtl/fms_step.sv
hw/rtl/focuser_motion_supervisor.sv
tb/sv/fms_motion_checker.sv
tb/sv/tb_focuser_motion_supervisor.sv
